// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/cbrg_pkg.sv =====
`default_nettype none
package cbrg_pkg;
  localparam logic [63:0] MixMul = 64'h2DEADBEA7DADD1E5;
  localparam logic [63:0] MixXor = 64'h0F1E2D3C4B5A6978;
  localparam int unsigned HalfShift = 32;
  localparam int unsigned Rounds = 4;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSeed  = 1'b0,
    CfgStart = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] count;
    logic [31:0] lo_b;
    logic [31:0] span;
  } job_t;

  typedef struct packed {
    logic        req_type;
    logic [63:0] explicit_step;
    logic [31:0] range_min;
    logic [31:0] range_max;
  } req_t;

  typedef struct packed {
    logic [63:0] raw_value;
    logic [31:0] ranged_value;
    logic        span_zero;
  } rsp_t;
endpackage
`default_nettype wire

// ===== rtl/cbrg_if.sv =====
`default_nettype none
interface cbrg_req_if;
  logic           valid;
  logic           ready;
  cbrg_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cbrg_rsp_if;
  logic           valid;
  logic           ready;
  cbrg_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/cbrg_front.sv =====
`default_nettype none
module cbrg_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_load_i,
  input  wire logic [63:0]    cfg_data_i,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  input  cbrg_pkg::req_t      req_i,
  output logic                job_valid_o,
  input  wire logic           job_ready_i,
  output cbrg_pkg::job_t      job_o
);
  localparam int unsigned PtrW = (cbrg_pkg::QueueDepth > 1) ? $clog2(cbrg_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(cbrg_pkg::QueueDepth + 1);

  logic [63:0]     step_q, step_d;
  logic            fire;
  cbrg_pkg::job_t  slot_q [cbrg_pkg::QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;
  cbrg_pkg::job_t  job_in;

  assign req_ready_o = (cnt_q != CntW'(cbrg_pkg::QueueDepth));
  assign fire = req_valid_i && req_ready_o;
  assign job_valid_o = (cnt_q != '0);
  assign pop = job_valid_o && job_ready_i;
  assign job_o = slot_q[rp_q];

  always_comb begin
    job_in.count = req_i.req_type ? req_i.explicit_step : step_q;
    job_in.lo_b  = req_i.range_min;
    job_in.span  = req_i.range_max - req_i.range_min + 32'd1;
    step_d = step_q;
    if (cfg_load_i) begin
      step_d = cfg_data_i;
    end else if (fire && !req_i.req_type) begin
      step_d = step_q + 64'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      step_q <= step_d;
      if (fire) begin
        wp_q <= (wp_q == PtrW'(cbrg_pkg::QueueDepth - 1)) ? '0 : wp_q + PtrW'(1);
      end
      if (pop) begin
        rp_q <= (rp_q == PtrW'(cbrg_pkg::QueueDepth - 1)) ? '0 : rp_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(fire) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) slot_q[wp_q] <= job_in;
  end
endmodule
`default_nettype wire

// ===== rtl/cbrg_back.sv =====
`default_nettype none
module cbrg_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [63:0]    seed_i,
  input  wire logic           job_valid_i,
  output logic                job_ready_o,
  input  cbrg_pkg::job_t      job_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_ready_i,
  output cbrg_pkg::rsp_t      rsp_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StMix  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;
  localparam int unsigned RndW = $clog2(cbrg_pkg::Rounds);

  logic [2:0]      st_q;
  logic [RndW-1:0] rnd_q;
  logic [4:0]      bit_q;
  logic [63:0]     v_q, prod_q;
  logic [31:0]     lo_q, span_q, rem_q, quo_q;
  logic [32:0]     trial;
  logic [63:0]     sum, rot;
  cbrg_pkg::rsp_t  out_q;
  logic            out_v_q;

  assign job_ready_o = (st_q == StIdle);
  assign rsp_valid_o = out_v_q;
  assign rsp_o = out_q;

  always_comb begin
    sum = prod_q + seed_i;
    rot = ((sum >> cbrg_pkg::HalfShift) | (sum << cbrg_pkg::HalfShift)) ^ cbrg_pkg::MixXor;
    trial = {rem_q, quo_q[31]} - {1'b0, span_q};
  end

  // Split 64x64 low product into 32-bit partials for timing.
  logic [63:0] p_ll;
  logic [31:0] p_lh, p_hl;
  always_comb begin
    p_ll = 64'(v_q[31:0]) * 64'(cbrg_pkg::MixMul[31:0]);
    p_lh = v_q[31:0] * cbrg_pkg::MixMul[63:32];
    p_hl = v_q[63:32] * cbrg_pkg::MixMul[31:0];
  end

  // Output register: load a finished item when the slot is free or drains now.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      out_q <= '0;
    end else if (st_q == StDone && (!out_v_q || rsp_ready_i)) begin
      out_q.raw_value <= v_q;
      out_q.ranged_value <= rem_q + lo_q;
      out_q.span_zero <= (span_q == 32'd0);
      out_v_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      rnd_q <= '0;
      bit_q <= '0;
      v_q <= '0;
      prod_q <= '0;
      lo_q <= '0;
      span_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
    end else begin
      case (st_q)
        StIdle: begin
          if (job_valid_i) begin
            v_q <= job_i.count;
            lo_q <= job_i.lo_b;
            span_q <= job_i.span;
            rnd_q <= '0;
            st_q <= StMul;
          end
        end
        StMul: begin
          prod_q <= p_ll + {p_lh + p_hl, 32'd0};
          st_q <= StMix;
        end
        StMix: begin
          v_q <= rot;
          rnd_q <= rnd_q + RndW'(1);
          if (rnd_q == RndW'(cbrg_pkg::Rounds - 1)) begin
            quo_q <= rot[31:0];
            rem_q <= '0;
            bit_q <= '0;
            st_q <= StDiv;
          end else begin
            st_q <= StMul;
          end
        end
        StDiv: begin
          // restoring division, one quotient bit per cycle
          if (span_q == 32'd0) begin
            rem_q <= quo_q;
            st_q <= StDone;
          end else begin
            if (!trial[32]) rem_q <= trial[31:0];
            else rem_q <= {rem_q[30:0], quo_q[31]};
            quo_q <= {quo_q[30:0], 1'b0};
            bit_q <= bit_q + 5'd1;
            if (bit_q == 5'd31) st_q <= StDone;
          end
        end
        StDone: begin
          if (!out_v_q || rsp_ready_i) begin
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/counter_based_random_generator.sv =====
// Path from the accepting edge to rsp valid: the queue slot, multiply/mix rounds, bit-serial
//   modulo (skipped for a full range), then the output register.
// The back end takes a new job only once the last one has left StDone.
// A two-entry queue lets requests be taken while the back end is busy.
// Reset: asynchronous, active low; clears seed, step counter, queue and output valid.
`default_nettype none
`include "assert_macros.svh"
module counter_based_random_generator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  cbrg_req_if.sink         req,
  cbrg_rsp_if.source       rsp
);
  logic [63:0]    seed_q;
  logic           job_valid, job_ready;
  cbrg_pkg::job_t job;

  // Hold the seed; a start_step write goes straight to the step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i && cfg_idx_i == cbrg_pkg::CfgSeed) begin
      seed_q <= cfg_data_i;
    end
  end

  cbrg_front u_front (
    .clk_i, .rst_ni,
    .cfg_load_i (cfg_we_i && cfg_idx_i == cbrg_pkg::CfgStart),
    .cfg_data_i,
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .req_i       (req.payload),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  cbrg_back u_back (
    .clk_i, .rst_ni,
    .seed_i      (seed_q),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .rsp_o       (rsp.payload)
  );

  // A full queue always offers a job; a stalled beat holds its payload.
  `ASSERT_IMPL(a_full_has_job, clk_i, rst_ni, !req.ready, job_valid)
  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.payload))
endmodule
`default_nettype wire

// ===== test/counter_based_random_generator_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module counter_based_random_generator_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        req_valid_i,
  input  wire logic        req_ready_i,
  input  cbrg_pkg::req_t   req_payload_i,
  input  wire logic        rsp_valid_i,
  input  wire logic        rsp_ready_i,
  input  cbrg_pkg::rsp_t   rsp_payload_i,
  output int               errors_o,
  output int               pending_o
);
  logic [63:0]    seed_q;
  logic [63:0]    count_q;
  cbrg_pkg::rsp_t expected_q[$];

  function automatic logic [63:0] mix_hash(logic [63:0] seed, logic [63:0] c);
    logic [63:0] v;
    v = c;
    for (int r = 0; r < 4; r++) begin
      v = v * cbrg_pkg::MixMul + seed;
      v = {v[31:0], v[63:32]} ^ cbrg_pkg::MixXor;
    end
    return v;
  endfunction

  function automatic cbrg_pkg::rsp_t predict_draw(cbrg_pkg::req_t rq, logic [63:0] c);
    cbrg_pkg::rsp_t o;
    logic [31:0] span;
    o.raw_value = mix_hash(seed_q, c);
    span = rq.range_max - rq.range_min + 32'd1;
    o.span_zero = (span == 32'd0);
    if (o.span_zero) o.ranged_value = o.raw_value[31:0] + rq.range_min;
    else o.ranged_value = (o.raw_value[31:0] % span) + rq.range_min;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors_o++;
  endtask

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q = '0;
      count_q = '0;
      errors_o = 0;
      expected_q.delete();
    end else begin
      // check the output beat first; a new input cannot finish in the same edge
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", rsp_payload_i.raw_value, '0);
        end else begin
          cbrg_pkg::rsp_t e;
          e = expected_q.pop_front();
          if (rsp_payload_i.raw_value !== e.raw_value)
            report_mismatch("raw_value", rsp_payload_i.raw_value, e.raw_value);
          if (rsp_payload_i.ranged_value !== e.ranged_value)
            report_mismatch("ranged_value", 64'(rsp_payload_i.ranged_value),
                            64'(e.ranged_value));
          if (rsp_payload_i.span_zero !== e.span_zero)
            report_mismatch("span_zero", 64'(rsp_payload_i.span_zero), 64'(e.span_zero));
        end
      end
      if (req_valid_i && req_ready_i) begin
        if (req_payload_i.req_type) begin
          expected_q.push_back(predict_draw(req_payload_i, req_payload_i.explicit_step));
        end else begin
          expected_q.push_back(predict_draw(req_payload_i, count_q));
          count_q = count_q + 64'd1;
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == cbrg_pkg::CfgSeed) seed_q = cfg_data_i;
        else if (cfg_idx_i == cbrg_pkg::CfgStart) count_q = cfg_data_i;
      end
    end
  end
endmodule
`default_nettype wire

// ===== test/counter_based_random_generator_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module counter_based_random_generator_tb;
  localparam int unsigned LatencyCycles = 44;
  localparam int unsigned CycleLimit = 900000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;
  int          errors;
  int          pending;
  int unsigned cycles;

  cbrg_req_if req_if ();
  cbrg_rsp_if rsp_if ();

  counter_based_random_generator uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req       (req_if.sink),
    .rsp       (rsp_if.source)
  );

  counter_based_random_generator_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_payload_i(req_if.payload),
    .rsp_valid_i  (rsp_if.valid),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_payload_i(rsp_if.payload),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: any hang ends the run as a failure.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Half the gaps are none at all, most others short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(120, 20);
  endfunction

  // Drop ready at random; the checker samples the same edges.
  initial begin
    int unsigned gap;
    gap = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (gap == 0) begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(9) == 0) gap = pick_gap();
      end else begin
        rsp_if.ready <= 1'b0;
        gap--;
      end
    end
  end

  task automatic write_reg(cbrg_pkg::cfg_idx_e idx, logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Hold valid until the beat is taken, then, if gaps is set, idle for a random gap.
  task automatic send_draw(logic kind, logic [63:0] step, logic [31:0] lo, logic [31:0] hi,
                           logic gaps);
    int unsigned gap;
    req_if.valid   <= 1'b1;
    req_if.payload <= '{req_type: kind, explicit_step: step, range_min: lo, range_max: hi};
    do @(posedge clk_i); while (!req_if.ready);
    gap = gaps ? pick_gap() : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait until every expected beat has come, then let the pipeline drain.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] rand_bound();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(15);
      3: return -$urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] lo;
    logic [31:0] hi;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state first, then corners of every field.
    send_draw(1'b0, '0, 32'd0, 32'd9, 1'b0);
    send_draw(1'b1, '0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);  // full range, zero span
    send_draw(1'b1, '1, 32'd5, 32'd5, 1'b0);                  // single value
    send_draw(1'b1, 64'h8000_0000_0000_0001, 32'd10, 32'd3, 1'b1);  // inverted bounds
    send_draw(1'b0, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_draw(1'b0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);   // span of zero, wrapped
    send_draw(1'b1, 64'h5555_AAAA_5555_AAAA, 32'h8000_0000, 32'h8000_0000, 1'b0);
    drain();
    // Counter wrap at the top of the 64-bit range, with the largest seed.
    write_reg(cbrg_pkg::CfgSeed, '1);
    write_reg(cbrg_pkg::CfgStart, 64'hFFFF_FFFF_FFFF_FFFE);
    repeat (4) send_draw(1'b0, '0, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_draw(1'b1, 64'hAAAA_5555_AAAA_5555, 32'hFFFF_FFF0, 32'h10, 1'b0);
    drain();

    // Random phases, each under its own seed and start value.
    for (int phase = 0; phase < 7; phase++) begin
      write_reg(cbrg_pkg::CfgSeed, phase == 0 ? 64'd0 : rand64());
      write_reg(cbrg_pkg::CfgStart, phase == 1 ? '1 : rand64());
      for (int n = 0; n < 100; n++) begin
        lo = rand_bound();
        hi = $urandom_range(3) == 0 ? lo + $urandom_range(40) : rand_bound();
        send_draw($urandom_range(1), rand64(), lo, hi, phase != 3);
      end
      drain();
    end

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/cbrg_pkg.sv
rtl/cbrg_if.sv
rtl/cbrg_front.sv
rtl/cbrg_back.sv
rtl/counter_based_random_generator.sv
test/counter_based_random_generator_checker.sv
test/counter_based_random_generator_tb.sv
